/* design/rrts_pkg.sv */
package rrts_pkg;

	localparam int NUM_SLOTS_DEF = 16;

	localparam logic [2:0] MODE_START    = 3'd0;
	localparam logic [2:0] MODE_STOP     = 3'd1;
	localparam logic [2:0] MODE_DISPATCH = 3'd2;
	localparam logic [2:0] MODE_COMPLETE = 3'd3;
	localparam logic [2:0] MODE_SNOOZE   = 3'd4;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_NONE    = 2'd2;
	localparam logic [1:0] STAT_IGNORED = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN,
		ST_RMW
	} rrts_state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] now;
		logic [14:0] new_task;
		logic [3:0]  slot_sel;
		logic [31:0] duration;
	} rrts_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        dispatched;
		logic [3:0]  chosen_slot;
		logic [14:0] chosen_task;
	} rrts_rsp_t;

	typedef struct packed {
		logic [14:0] task_id;
		logic [31:0] period;
		logic [31:0] wake;
	} rrts_entry_t;

endpackage

/* design/round_robin_timed_task_scheduler_core.sv */
// Round robin task scheduler with wake times. A request is taken when start is high and busy
// is low; its single result appears on rsp for exactly one cycle with done high, and the
// receiver cannot stall it. Stop and ignored requests, among them dispatch while suspended or
// running, finish in the cycle in which they are taken. Start searches the slot valid bits
// one slot per cycle. Dispatch reads the slot memory once per cycle, round robin from the
// slot after the current one. Complete and snooze do a read-modify-write of the current
// slot. The result is shown in the cycle after the last working cycle, and a new request
// may be taken in that same cycle.
// The suspend register is written through the cfg channel, which is always ready.
module round_robin_timed_task_scheduler_core
	import rrts_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  rrts_req_t req,
	output logic      done,
	output rrts_rsp_t rsp,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int EW = $bits(rrts_entry_t);

	rrts_state_t state_q, state_d;

	logic [NUM_SLOTS-1:0] valid_q, valid_d;
	logic [SW-1:0]        cur_q, cur_d;
	logic                 run_q, run_d;
	logic [SW-1:0]        idx_q, idx_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic                 chk_s1, chk_d;
	logic [SW-1:0]        chk_addr_s1, chk_addr_d;
	logic                 suspend_q;
	rrts_req_t            item_q;
	logic                 done_q, fin;
	rrts_rsp_t            rsp_q, rsp_d;

	logic          ram_we;
	logic [SW-1:0] ram_waddr, ram_raddr;
	rrts_entry_t   ram_wdata, rd_ent;
	logic [EW-1:0] ram_rdata;
	logic          hit;
	logic [SW+3:0] sel_w;

	function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] a);
		logic [SW-1:0] r;
		if (a == SW'(NUM_SLOTS - 1)) begin
			r = '0;
		end else begin
			r = a + SW'(1);
		end
		return r;
	endfunction

	function automatic logic [3:0] slot4(input logic [SW-1:0] a);
		logic [SW+3:0] w;
		w = {4'b0, a};
		return w[3:0];
	endfunction

	rrts_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(EW'(ram_wdata)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_ent = rrts_entry_t'(ram_rdata);
	assign sel_w = {{SW{1'b0}}, req.slot_sel};
	assign hit = chk_s1 && valid_q[chk_addr_s1] && (item_q.now >= rd_ent.wake);

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		rsp_d      = '{status: STAT_IGNORED, dispatched: 1'b0, chosen_slot: 4'd0,
			chosen_task: 15'd0};
		ram_we     = 1'b0;
		ram_waddr  = cur_q;
		ram_wdata  = rd_ent;
		ram_raddr  = cur_q;
		valid_d    = valid_q;
		cur_d      = cur_q;
		run_d      = run_q;
		idx_d      = idx_q;
		cnt_d      = cnt_q;
		chk_d      = 1'b0;
		chk_addr_d = chk_addr_s1;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req.mode) inside
						MODE_START: begin
							idx_d   = '0;
							state_d = ST_FIND;
						end
						MODE_STOP: begin
							fin = 1'b1;
							if ({3'b0, req.slot_sel} < 7'(NUM_SLOTS)) begin
								valid_d[sel_w[SW-1:0]] = 1'b0;
								rsp_d.status = STAT_OK;
							end
						end
						MODE_DISPATCH: begin
							if (suspend_q || run_q) begin
								fin = 1'b1;
							end else begin
								idx_d   = wrap_inc(cur_q);
								cnt_d   = '0;
								state_d = ST_SCAN;
							end
						end
						MODE_COMPLETE, MODE_SNOOZE: begin
							if (run_q) begin
								state_d = ST_RMW;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_FIND: begin
				if (!valid_q[idx_q]) begin
					ram_we             = 1'b1;
					ram_waddr          = idx_q;
					ram_wdata.task_id  = item_q.new_task;
					ram_wdata.period   = item_q.duration;
					ram_wdata.wake     = item_q.now;
					valid_d[idx_q]     = 1'b1;
					fin                = 1'b1;
					rsp_d.status       = STAT_OK;
					rsp_d.chosen_slot  = slot4(idx_q);
					state_d            = ST_IDLE;
				end else if (idx_q == SW'(NUM_SLOTS - 1)) begin
					fin          = 1'b1;
					rsp_d.status = STAT_FULL;
					state_d      = ST_IDLE;
				end else begin
					idx_d = idx_q + SW'(1);
				end
			end
			ST_SCAN: begin
				ram_raddr = idx_q;
				if (hit) begin
					fin               = 1'b1;
					rsp_d.status      = STAT_OK;
					rsp_d.dispatched  = 1'b1;
					rsp_d.chosen_slot = slot4(chk_addr_s1);
					rsp_d.chosen_task = rd_ent.task_id;
					cur_d             = chk_addr_s1;
					run_d             = 1'b1;
					state_d           = ST_IDLE;
				end else if (cnt_q == CW'(NUM_SLOTS)) begin
					fin          = 1'b1;
					rsp_d.status = STAT_NONE;
					state_d      = ST_IDLE;
				end else begin
					chk_d      = 1'b1;
					chk_addr_d = idx_q;
					idx_d      = wrap_inc(idx_q);
					cnt_d      = cnt_q + CW'(1);
				end
			end
			ST_RMW: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				if (item_q.mode == MODE_COMPLETE) begin
					ram_wdata.wake = item_q.now + rd_ent.period;
					run_d          = 1'b0;
				end else begin
					ram_wdata.period = item_q.duration;
				end
				fin          = 1'b1;
				rsp_d.status = STAT_OK;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cur_q     <= '0;
			run_q     <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
			chk_s1    <= 1'b0;
			done_q    <= 1'b0;
			suspend_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
			cur_q   <= cur_d;
			run_q   <= run_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			chk_s1  <= chk_d;
			done_q  <= fin;
			if (cfg_valid && cfg_ready) begin
				suspend_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_s1 <= chk_addr_d;
		rsp_q       <= rsp_d;
		if (start && !busy) begin
			item_q <= req;
		end
	end

	a_run_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(run_q) |-> $past(state_q == ST_SCAN))
		else $error("running set outside a dispatch scan");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_FIND || state_q == ST_RMW))
		else $error("slot memory written outside start or reschedule");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q != ST_IDLE) || $past(start)))
		else $error("result shown without a request");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_SLOTS))
		else $error("scan count beyond slot count");

endmodule

/* design/rrts_ram.sv */
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* verif/round_robin_timed_task_scheduler_core_tb.sv */
`timescale 1ns / 100ps

class sched_scoreboard;
	localparam int SLOTS = rrts_pkg::NUM_SLOTS_DEF;

	bit                  slot_used[SLOTS];
	logic [14:0]         slot_task_id[SLOTS];
	logic [31:0]         slot_period[SLOTS];
	logic [31:0]         slot_wake[SLOTS];
	logic [3:0]          cur_slot;
	bit                  running;
	bit                  suspend;
	int                  errors;
	rrts_pkg::rrts_rsp_t expected_rsp[$];

	function new();
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		cur_slot = '0;
		running = 1'b0;
		suspend = 1'b0;
		errors = 0;
	endfunction

	// Updates the table for one accepted item and queues the response it must produce.
	function logic [1:0] predict_item(rrts_pkg::rrts_req_t r);
		rrts_pkg::rrts_rsp_t want;
		int s;
		bit found;
		want = '0;
		want.status = rrts_pkg::STAT_IGNORED;
		found = 1'b0;
		case (r.mode)
		rrts_pkg::MODE_START: begin
			want.status = rrts_pkg::STAT_FULL;
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && !slot_used[i]) begin
					found = 1'b1;
					slot_used[i] = 1'b1;
					slot_task_id[i] = r.new_task;
					slot_wake[i] = r.now;
					slot_period[i] = r.duration;
					want.status = rrts_pkg::STAT_OK;
					want.chosen_slot = 4'(i);
				end
			end
		end
		rrts_pkg::MODE_STOP: begin
			if (int'(r.slot_sel) < SLOTS) begin
				slot_used[r.slot_sel] = 1'b0;
				want.status = rrts_pkg::STAT_OK;
			end
		end
		rrts_pkg::MODE_DISPATCH: begin
			if (!suspend && !running) begin
				want.status = rrts_pkg::STAT_NONE;
				for (int k = 1; k <= SLOTS; k++) begin
					s = (int'(cur_slot) + k) % SLOTS;
					if (!found && slot_used[s] && r.now >= slot_wake[s]) begin
						found = 1'b1;
						cur_slot = 4'(s);
						running = 1'b1;
						want.status = rrts_pkg::STAT_OK;
						want.dispatched = 1'b1;
						want.chosen_slot = 4'(s);
						want.chosen_task = slot_task_id[s];
					end
				end
			end
		end
		rrts_pkg::MODE_COMPLETE: begin
			if (running) begin
				slot_wake[cur_slot] = r.now + slot_period[cur_slot];
				running = 1'b0;
				want.status = rrts_pkg::STAT_OK;
			end
		end
		rrts_pkg::MODE_SNOOZE: begin
			if (running) begin
				slot_period[cur_slot] = r.duration;
				want.status = rrts_pkg::STAT_OK;
			end
		end
		default: begin
		end
		endcase
		expected_rsp.push_back(want);
		return want.status;
	endfunction

	function void check_result(rrts_pkg::rrts_rsp_t got);
		rrts_pkg::rrts_rsp_t want;
		if (expected_rsp.size() == 0) begin
			$error("response with no item outstanding: %h", got);
			errors++;
			return;
		end
		want = expected_rsp.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.dispatched !== want.dispatched) begin
			$error("dispatched: expected %0d, got %0d", want.dispatched, got.dispatched);
			errors++;
		end
		if (got.chosen_slot !== want.chosen_slot) begin
			$error("chosen_slot: expected %0d, got %0d", want.chosen_slot, got.chosen_slot);
			errors++;
		end
		if (got.chosen_task !== want.chosen_task) begin
			$error("chosen_task: expected %0d, got %0d", want.chosen_task, got.chosen_task);
			errors++;
		end
	endfunction
endclass

module round_robin_timed_task_scheduler_core_tb;
	import rrts_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 205;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	rrts_req_t req;
	logic      done;
	rrts_rsp_t rsp;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;

	sched_scoreboard sb;
	int              idle_pct;
	int              stop_pct;
	int              quiet_cycles;
	logic [31:0]     ms_clock;

	round_robin_timed_task_scheduler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(rsp);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic rrts_req_t make_item(logic [2:0] mode, logic [31:0] now,
			logic [14:0] new_task, logic [3:0] slot_sel, logic [31:0] duration);
		rrts_req_t r;
		r.mode = mode;
		r.now = now;
		r.new_task = new_task;
		r.slot_sel = slot_sel;
		r.duration = duration;
		return r;
	endfunction

	function automatic rrts_req_t random_item();
		rrts_req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 4) begin
			ms_clock = $urandom();
		end else if (pick < 6) begin
			ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 60);
		end else begin
			ms_clock = ms_clock + $urandom_range(0, 25);
		end
		r.now = ($urandom_range(99) < 3) ? 32'($urandom()) : ms_clock;
		pick = $urandom_range(99);
		if (pick < 70) begin
			r.duration = $urandom_range(0, 40);
		end else if (pick < 85) begin
			r.duration = $urandom();
		end else begin
			r.duration = 32'hFFFF_FFFF - $urandom_range(0, 40);
		end
		r.new_task = 15'($urandom_range(0, 32767));
		r.slot_sel = 4'($urandom_range(0, 15));
		pick = $urandom_range(99);
		if (pick < stop_pct) begin
			r.mode = MODE_STOP;
		end else if (pick >= 95) begin
			r.mode = 3'($urandom_range(0, 7));
		end else if (pick >= 92) begin
			r.mode = 3'($urandom_range(5, 7));
		end else if (sb.running) begin
			pick = $urandom_range(99);
			r.mode = (pick < 55) ? MODE_COMPLETE : (pick < 75) ? MODE_SNOOZE :
				(pick < 90) ? MODE_START : MODE_DISPATCH;
		end else begin
			pick = $urandom_range(99);
			r.mode = (pick < 35) ? MODE_START : (pick < 90) ? MODE_DISPATCH :
				(pick < 95) ? MODE_COMPLETE : MODE_SNOOZE;
		end
		return r;
	endfunction

	task automatic send_item(input rrts_req_t r, output logic [1:0] status);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		status = sb.predict_item(r);
	endtask

	task automatic pause_sender();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic write_suspend(input logic value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.suspend = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		logic [1:0] status;
		send_item(make_item(MODE_DISPATCH, 32'd0, 15'd3, 4'd2, 32'd9), status);
		send_item(make_item(MODE_COMPLETE, 32'd7, 15'd1, 4'd1, 32'd1), status);
		send_item(make_item(MODE_SNOOZE, 32'd7, 15'd1, 4'd1, 32'd1), status);
		for (int m = 5; m <= 7; m++) begin
			send_item(make_item(3'(m), 32'hFFFF_FFFF, 15'h7FFF, 4'hF, 32'hFFFF_FFFF),
				status);
		end
		send_item(make_item(MODE_START, 32'hFFFF_FFFF, 15'h7FFF, 4'hF, 32'hFFFF_FFFF),
			status);
		send_item(make_item(MODE_START, 32'd0, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_DISPATCH, 32'd0, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_DISPATCH, 32'hFFFF_FFFF, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_SNOOZE, 32'd0, 15'd0, 4'd0, 32'hFFFF_FFFF), status);
		// The wake time wraps past the top of the 32-bit range.
		send_item(make_item(MODE_COMPLETE, 32'd5, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_DISPATCH, 32'd3, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_DISPATCH, 32'hFFFF_FFFF, 15'd0, 4'd0, 32'd0), status);
		// Freeing the running slot leaves the task running until complete.
		send_item(make_item(MODE_STOP, 32'd0, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_COMPLETE, 32'd0, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_STOP, 32'd0, 15'd0, 4'hF, 32'd0), status);
		send_item(make_item(MODE_START, 32'd20, 15'h2AAA, 4'd5, 32'd4), status);
		drain();
		write_suspend(1'b1);
		send_item(make_item(MODE_DISPATCH, 32'hFFFF_FFFF, 15'd0, 4'd0, 32'd0), status);
		send_item(make_item(MODE_COMPLETE, 32'd1, 15'd0, 4'd0, 32'd0), status);
		drain();
	endtask

	initial begin
		int phase_idle[NUM_PHASES];
		int phase_stop[NUM_PHASES];
		bit phase_suspend[NUM_PHASES];
		int counted;
		logic [1:0] status;

		phase_idle = '{0, 45, 25, 0, 45, 25, 45, 0};
		phase_stop = '{8, 25, 8, 25, 12, 30, 8, 15};
		phase_suspend = '{0, 0, 1, 0, 0, 1, 0, 0};
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		quiet_cycles = 0;
		idle_pct = 0;
		stop_pct = 10;
		ms_clock = '0;
		sb = new();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_suspend(1'b0);
		run_directed();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			write_suspend(phase_suspend[ph]);
			idle_pct = phase_idle[ph];
			stop_pct = phase_stop[ph];
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				send_item(random_item(), status);
				counted++;
				if ($urandom_range(199) == 0) begin
					drain();
				end else begin
					pause_sender();
				end
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
